>>> src/lkcd_pkg.sv
package lkcd_pkg;

  // Number of keys on the ladder
  localparam int BUTTON_COUNT = 9;
  localparam int BTN_W = $clog2(BUTTON_COUNT);

  // Command codes
  localparam logic [3:0] CMD_NONE       = 4'd0;
  localparam logic [3:0] CMD_PRESET     = 4'd1;
  localparam logic [3:0] CMD_BANK_UP    = 4'd2;
  localparam logic [3:0] CMD_BANK_DOWN  = 4'd3;
  localparam logic [3:0] CMD_PROG_UP    = 4'd4;
  localparam logic [3:0] CMD_PROG_DOWN  = 4'd5;
  localparam logic [3:0] CMD_SET_PROG   = 4'd6;
  localparam logic [3:0] CMD_RESET      = 4'd7;
  localparam logic [3:0] CMD_ENTER_PROG = 4'd8;
  localparam logic [3:0] CMD_EXIT_PROG  = 4'd9;

  // Configuration register indexes
  localparam logic [2:0] REG_FIRST_PRESET = 3'd0;
  localparam logic [2:0] REG_BANK_UP      = 3'd1;
  localparam logic [2:0] REG_BANK_DOWN    = 3'd2;
  localparam logic [2:0] REG_TAP          = 3'd3;
  localparam logic [2:0] REG_PROGRAM      = 3'd4;
  localparam logic [2:0] REG_RESET_HOLD   = 3'd5;
  localparam logic [2:0] REG_PROGRAM_HOLD = 3'd6;

  // Ladder thresholds: below NONE_BOUND nothing is pressed; below
  // LADDER_BOUNDS[k] the key is 8-k; at or above the last bound key 0.
  localparam logic [9:0] NONE_BOUND = 10'd150;
  localparam logic [9:0] LADDER_BOUNDS [8] = '{
    10'd250, 10'd350, 10'd450, 10'd550, 10'd650, 10'd760, 10'd860, 10'd970
  };

  // Power-on register values
  localparam logic [2:0]  RST_FIRST_PRESET = 3'd0;
  localparam logic [3:0]  RST_BANK_UP      = 4'd5;
  localparam logic [3:0]  RST_BANK_DOWN    = 4'd6;
  localparam logic [3:0]  RST_TAP          = 4'd7;
  localparam logic [3:0]  RST_PROGRAM      = 4'd8;
  localparam logic [15:0] RST_RESET_HOLD   = 16'd3000;
  localparam logic [15:0] RST_PROGRAM_HOLD = 16'd1000;

  // Key assignments and hold limits
  typedef struct packed {
    logic [2:0]  first_preset_button;
    logic [3:0]  bank_up_button;
    logic [3:0]  bank_down_button;
    logic [3:0]  tap_button;
    logic [3:0]  program_button;
    logic [15:0] reset_hold_ms;
    logic [15:0] program_hold_ms;
  } cfg_t;

  // Decoded ladder reading
  typedef struct packed {
    logic             pressed;
    logic [BTN_W-1:0] idx;
  } btn_t;

endpackage

>>> src/lkcd_cfg_regs.sv
module lkcd_cfg_regs
  import lkcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  // Register file; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_preset_button <= RST_FIRST_PRESET;
      cfg.bank_up_button      <= RST_BANK_UP;
      cfg.bank_down_button    <= RST_BANK_DOWN;
      cfg.tap_button          <= RST_TAP;
      cfg.program_button      <= RST_PROGRAM;
      cfg.reset_hold_ms       <= RST_RESET_HOLD;
      cfg.program_hold_ms     <= RST_PROGRAM_HOLD;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FIRST_PRESET: cfg.first_preset_button <= wr_data[2:0];
        REG_BANK_UP:      cfg.bank_up_button      <= wr_data[3:0];
        REG_BANK_DOWN:    cfg.bank_down_button    <= wr_data[3:0];
        REG_TAP:          cfg.tap_button          <= wr_data[3:0];
        REG_PROGRAM:      cfg.program_button      <= wr_data[3:0];
        REG_RESET_HOLD:   cfg.reset_hold_ms       <= wr_data;
        REG_PROGRAM_HOLD: cfg.program_hold_ms     <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> src/lkcd_ladder_decode.sv
module lkcd_ladder_decode
  import lkcd_pkg::*;
(
  input  logic [9:0] adc_value,
  output btn_t       btn
);

  // Threshold compares; the lowest bound that is passed wins
  always_comb begin
    btn.pressed = (adc_value >= NONE_BOUND);
    btn.idx     = '0;
    for (int k = 7; k >= 0; k--) begin
      if (adc_value < LADDER_BOUNDS[k]) begin
        btn.idx = BTN_W'(8 - k);
      end
    end
  end

endmodule

>>> src/lkcd_core.sv
module lkcd_core
  import lkcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  btn_t        btn,
  input  logic [31:0] now_ms,
  input  cfg_t        cfg,
  output logic [3:0]  command,
  output logic [2:0]  preset_index,
  output logic        in_program_mode
);

  logic [BUTTON_COUNT-1:0] held_flags;
  logic [BUTTON_COUNT-1:0] held_flags_next;
  logic [31:0]             change_time [BUTTON_COUNT];
  logic                    program_mode_flag;
  logic                    program_mode_flag_next;

  logic             rel_any;
  logic [BTN_W-1:0] rel_idx;
  logic             time_wr;
  logic [BTN_W-1:0] time_idx;
  logic [31:0]      held_ms;
  logic [3:0]       btn_wide;
  logic [3:0]       preset_last;
  logic             in_preset;

  // Lowest held key
  always_comb begin
    rel_any = 1'b0;
    rel_idx = '0;
    for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
      if (held_flags[i]) begin
        rel_any = 1'b1;
        rel_idx = BTN_W'(i);
      end
    end
  end

  assign held_ms     = now_ms - change_time[rel_idx];
  assign btn_wide    = 4'(btn.idx);
  assign preset_last = {1'b0, cfg.first_preset_button} + 4'd4;
  assign in_preset   = (btn_wide >= {1'b0, cfg.first_preset_button}) &&
                       (btn_wide <= preset_last);

  // Press / release decision
  always_comb begin
    command                = CMD_NONE;
    preset_index           = '0;
    program_mode_flag_next = program_mode_flag;
    held_flags_next        = held_flags;
    time_wr                = 1'b0;
    time_idx               = btn.idx;
    if (btn.pressed) begin
      if (!held_flags[btn.idx]) begin
        time_wr                  = 1'b1;
        held_flags_next[btn.idx] = 1'b1;
        priority if (!program_mode_flag && in_preset) begin
          command      = CMD_PRESET;
          preset_index = 3'(btn_wide - {1'b0, cfg.first_preset_button});
        end else if (btn_wide == cfg.bank_up_button && !program_mode_flag) begin
          command = CMD_BANK_UP;
        end else if (btn_wide == cfg.bank_down_button && !program_mode_flag) begin
          command = CMD_BANK_DOWN;
        end else if (btn_wide == cfg.bank_up_button) begin
          command = CMD_PROG_UP;
        end else if (btn_wide == cfg.bank_down_button) begin
          command = CMD_PROG_DOWN;
        end else if (btn_wide == cfg.tap_button && program_mode_flag) begin
          command = CMD_SET_PROG;
        end else begin
          command = CMD_NONE;
        end
      end
    end else if (rel_any) begin
      time_wr                  = 1'b1;
      time_idx                 = rel_idx;
      held_flags_next[rel_idx] = 1'b0;
      if (4'(rel_idx) == cfg.program_button) begin
        priority if (program_mode_flag) begin
          program_mode_flag_next = 1'b0;
          command                = CMD_EXIT_PROG;
        end else if (held_ms > {16'd0, cfg.reset_hold_ms}) begin
          command = CMD_RESET;
        end else if (held_ms > {16'd0, cfg.program_hold_ms}) begin
          program_mode_flag_next = 1'b1;
          command                = CMD_ENTER_PROG;
        end else begin
          command = CMD_NONE;
        end
      end
    end
  end

  assign in_program_mode = program_mode_flag_next;

  // Key state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_flags        <= '0;
      program_mode_flag <= 1'b0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        change_time[i] <= '0;
      end
    end else if (step) begin
      held_flags        <= held_flags_next;
      program_mode_flag <= program_mode_flag_next;
      if (time_wr) begin
        change_time[time_idx] <= now_ms;
      end
    end
  end

  // A step never leaves the key it released still marked held
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (step && !btn.pressed && rel_any) |=> !held_flags[$past(rel_idx)])
    else $error("released key still held");

endmodule

>>> src/ladder_keypad_command_decoder_unit.sv
// Channel  Dir  Handshake                 Payload
// s        in   s_tvalid / s_tready       s_tdata: adc_value[9:0], now_ms[41:10]
// m        out  m_tvalid / m_tready       m_tdata: command[3:0], preset_index[6:4],
//                                                  in_program_mode[7]
// cfg      in   cfg_valid / cfg_ready     cfg_index[2:0], cfg_data[15:0]
//
// One poll per cycle sustained while m is not stalled; a poll's result reaches m
// through the input register, then decode and key state into the result register.
// Reset (rst, synchronous) clears key flags, times, program mode and registers
// to their power-on values; no clearing pass is needed.
// A stall on m holds the result; s keeps accepting until the input register
// is also full. cfg is always ready.
module ladder_keypad_command_decoder_unit
  import lkcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // adc_value[9:0], now_ms[41:10], zero[47:42]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // command[3:0], preset_index[6:4], in_program_mode[7]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg;
  btn_t        btn;
  logic        in_valid;
  logic [9:0]  in_adc;
  logic [31:0] in_now;
  logic        advance;
  logic        s_fire;
  logic [3:0]  command;
  logic [2:0]  preset_index;
  logic        in_program_mode;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign s_fire    = s_tvalid && s_tready;

  lkcd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_fire || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_adc <= s_tdata[9:0];
      in_now <= s_tdata[41:10];
    end
  end

  lkcd_ladder_decode u_decode (
    .adc_value (in_adc),
    .btn       (btn)
  );

  lkcd_core u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .btn             (btn),
    .now_ms          (in_now),
    .cfg             (cfg),
    .command         (command),
    .preset_index    (preset_index),
    .in_program_mode (in_program_mode)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= advance || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {in_program_mode, preset_index, command};
    end
  end

  // With the result register free, the input side is never blocked
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  a_preset_outside_prog: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3:0] == CMD_PRESET) |-> !m_tdata[7])
    else $error("preset issued in program mode");

  a_preset_index_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3:0] != CMD_PRESET) |-> (m_tdata[6:4] == 3'd0))
    else $error("preset index without preset command");

  a_mode_change: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[3:0] == CMD_ENTER_PROG || m_tdata[3:0] == CMD_EXIT_PROG))
    |-> (m_tdata[7] == (m_tdata[3:0] == CMD_ENTER_PROG)))
    else $error("program mode flag disagrees with mode command");

endmodule
